// ===== src/bits_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and width helpers for the irradiance table sampler
// no dependencies; imported by every other file of the block

package bits_pkg;

  // default table geometry
  localparam int BITS_TABLE_COLUMNS = 64;
  localparam int BITS_TABLE_ROWS    = 16;

  // field widths
  localparam int INDEX_W  = 10;
  localparam int TEXEL_W  = 32;
  localparam int COS_W    = 16;
  localparam int HEIGHT_W = 24;
  localparam int OUT_W    = 31;
  localparam int FRAC_W   = 16;

  // height clamp range is [1, 61440], which fits 16 unsigned bits
  localparam int HEIGHT_TOP = 61440;
  localparam int HCLAMP_W   = 16;

  // 2^16 / 61440 = 16 / 15, so y = p + floor(p / 15) with p = h * (rows - 1)
  localparam int ROW_SCALE_DEN = 15;
  localparam int ROW_SCALE_SH  = 4;

  // rounding term of every blend
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  // four banks, indexed {row parity, column parity}
  localparam int BANKS  = 4;
  localparam int BANK_W = 2;

  localparam int CHANNELS = 3;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [TEXEL_W-1:0] red;
    logic signed [TEXEL_W-1:0] green;
    logic signed [TEXEL_W-1:0] blue;
  } texel_t;

  // per-item control that travels with the addresses and the read data
  typedef struct packed {
    logic              is_sample;
    logic              row_odd;
    logic              col_odd;
    logic              row_edge;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
  } samp_ctrl_t;

  // bits needed to address half of n rows or columns, at least one
  function automatic int half_w(input int n);
    int half;
    half = (n + 1) >> 1;
    return ($clog2(half) > 0) ? $clog2(half) : 1;
  endfunction

endpackage

// ===== src/bits_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for the sampler's input and result items
// depends on bits_pkg for field widths

interface bits_in_if import bits_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [INDEX_W-1:0]         texel_index;
  logic signed [TEXEL_W-1:0]  texel_red;
  logic signed [TEXEL_W-1:0]  texel_green;
  logic signed [TEXEL_W-1:0]  texel_blue;
  logic signed [COS_W-1:0]    source_cosine;
  logic signed [HEIGHT_W-1:0] height_km;

  modport source(
    output valid, action, texel_index, texel_red, texel_green, texel_blue,
    output source_cosine, height_km,
    input  ready
  );
  modport sink(
    input  valid, action, texel_index, texel_red, texel_green, texel_blue,
    input  source_cosine, height_km,
    output ready
  );
endinterface

interface bits_out_if import bits_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red;
  logic [OUT_W-1:0] green;
  logic [OUT_W-1:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// ===== src/bits_coord.sv =====
`timescale 1ns / 1ps
// three-stage front end: texel coordinates, fractions and bank addresses
// depends on bits_pkg and bits_in_if

module bits_coord import bits_pkg::*; #(
  parameter  int TABLE_COLUMNS = BITS_TABLE_COLUMNS,
  parameter  int TABLE_ROWS    = BITS_TABLE_ROWS,
  localparam int HC_W          = half_w(TABLE_COLUMNS),
  localparam int HR_W          = half_w(TABLE_ROWS)
) (
  input  logic          clk,
  input  logic          rst_n,
  bits_in_if.sink       in_item,
  output logic          dn_valid,
  input  logic          dn_ready,
  output samp_ctrl_t    dn_ctrl,
  output texel_t        dn_texel,
  output logic [HR_W-1:0] dn_hr_e,
  output logic [HR_W-1:0] dn_hr_o,
  output logic [HC_W-1:0] dn_hc_e,
  output logic [HC_W-1:0] dn_hc_o
);

  localparam int COL_W       = $clog2(TABLE_COLUMNS);
  localparam int ROW_W       = $clog2(TABLE_ROWS);
  localparam int TEXEL_COUNT = TABLE_ROWS * TABLE_COLUMNS;
  localparam int XQ_W        = COS_W + COL_W;
  localparam int P_W         = HCLAMP_W + ROW_W;
  localparam int RECIP_SHIFT = P_W + ROW_SCALE_SH;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + ROW_SCALE_DEN - 1) / ROW_SCALE_DEN;
  localparam int QP_W        = 2 * P_W + 1;
  localparam int DIV_SHIFT   = INDEX_W + COL_W;
  localparam int DIV_MULT    = ((1 << DIV_SHIFT) + TABLE_COLUMNS - 1) / TABLE_COLUMNS;
  localparam int WP_W        = DIV_SHIFT + ROW_W;

  logic en_a, en_b, en_c;

  // stage a
  logic                va_r, va_nxt;
  logic                a_sample_r;
  texel_t              a_texel_r;
  logic [INDEX_W-1:0]  a_idx_r;
  logic [XQ_W-1:0]     a_xq_r;
  logic [P_W-1:0]      a_p_r;
  logic [WP_W-1:0]     a_wprod_r;
  logic                is_sample;
  logic                idx_ok;
  logic [COS_W-1:0]    cos_u;
  logic [HCLAMP_W-1:0] h_cl;

  // stage b
  logic                vb_r;
  logic                b_sample_r;
  texel_t              b_texel_r;
  logic [INDEX_W-1:0]  b_idx_r;
  logic [COL_W-1:0]    b_ix_r;
  logic [FRAC_W-1:0]   b_fx_r;
  logic [P_W-1:0]      b_p_r;
  logic [P_W-1:0]      b_q_r;
  logic [ROW_W-1:0]    b_wrow_r;
  logic [QP_W-1:0]     q_prod;

  // stage c
  logic                vc_r;
  samp_ctrl_t          ctrl_r, ctrl_nxt;
  texel_t              c_texel_r;
  logic [HR_W-1:0]     hr_e_r, hr_o_r, hr_e_nxt, hr_o_nxt;
  logic [HC_W-1:0]     hc_e_r, hc_o_r, hc_e_nxt, hc_o_nxt;
  logic [P_W-1:0]      yq;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;

  assign en_c = !vc_r || dn_ready;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_item.ready = en_a;

  // stage a: offset cosine, clamped height, products
  always_comb begin
    is_sample = (action_t'(in_item.action) == ACT_SAMPLE);
    idx_ok    = (32'(in_item.texel_index) < 32'(TEXEL_COUNT));
    // writes past the table are dropped here
    va_nxt    = in_item.valid && (is_sample || idx_ok);
    cos_u     = {~in_item.source_cosine[COS_W-1], in_item.source_cosine[COS_W-2:0]};
    if (in_item.height_km <= 0) begin
      h_cl = HCLAMP_W'(1);
    end else if (in_item.height_km > HEIGHT_TOP) begin
      h_cl = HCLAMP_W'(HEIGHT_TOP);
    end else begin
      h_cl = in_item.height_km[HCLAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en_a) begin
      va_r <= va_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_sample_r <= is_sample;
      a_texel_r  <= '{red: in_item.texel_red, green: in_item.texel_green,
                      blue: in_item.texel_blue};
      a_idx_r    <= in_item.texel_index;
      a_xq_r     <= XQ_W'(cos_u) * XQ_W'(TABLE_COLUMNS - 1);
      a_p_r      <= P_W'(h_cl) * P_W'(TABLE_ROWS - 1);
      // reciprocal multiply for the write row, index / columns
      a_wprod_r  <= WP_W'(in_item.texel_index) * WP_W'(DIV_MULT);
    end
  end

  // stage b: divide by 15 through a reciprocal, split column coordinate
  assign q_prod = QP_W'(a_p_r) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_sample_r <= a_sample_r;
      b_texel_r  <= a_texel_r;
      b_idx_r    <= a_idx_r;
      b_ix_r     <= a_xq_r[FRAC_W +: COL_W];
      b_fx_r     <= a_xq_r[FRAC_W-1:0];
      b_p_r      <= a_p_r;
      b_q_r      <= P_W'(q_prod >> RECIP_SHIFT);
      b_wrow_r   <= a_wprod_r[DIV_SHIFT +: ROW_W];
    end
  end

  // stage c: row coordinate, bank halves
  always_comb begin
    yq  = b_p_r + b_q_r;
    row = b_sample_r ? yq[FRAC_W +: ROW_W] : b_wrow_r;
    col = b_sample_r ? b_ix_r
                     : COL_W'(b_idx_r - INDEX_W'(32'(b_wrow_r) * TABLE_COLUMNS));

    ctrl_nxt.is_sample = b_sample_r;
    ctrl_nxt.row_odd   = row[0];
    ctrl_nxt.col_odd   = col[0];
    ctrl_nxt.row_edge  = b_sample_r && (row == ROW_W'(TABLE_ROWS - 1));
    ctrl_nxt.frac_x    = b_fx_r;
    ctrl_nxt.frac_y    = yq[FRAC_W-1:0];

    // for a sample the even neighbor of an odd base sits one half further on
    hr_e_nxt = HR_W'((row >> 1) + ROW_W'(b_sample_r & row[0]));
    hr_o_nxt = HR_W'(row >> 1);
    hc_e_nxt = HC_W'((col >> 1) + COL_W'(b_sample_r & col[0]));
    hc_o_nxt = HC_W'(col >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      ctrl_r    <= ctrl_nxt;
      c_texel_r <= b_texel_r;
      hr_e_r    <= hr_e_nxt;
      hr_o_r    <= hr_o_nxt;
      hc_e_r    <= hc_e_nxt;
      hc_o_r    <= hc_o_nxt;
    end
  end

  assign dn_valid = vc_r;
  assign dn_ctrl  = ctrl_r;
  assign dn_texel = c_texel_r;
  assign dn_hr_e  = hr_e_r;
  assign dn_hr_o  = hr_o_r;
  assign dn_hc_e  = hc_e_r;
  assign dn_hc_o  = hc_o_r;

`ifndef SYNTHESIS
  // the base column stays below the last one, so the right neighbor is real
  a_col_base: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && b_sample_r) |-> (32'(b_ix_r) <= TABLE_COLUMNS - 2))
    else $error("column base reached last column");

  // the reciprocal row of a write must be the true quotient
  a_write_row: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !b_sample_r) |->
      ((32'(b_wrow_r) * TABLE_COLUMNS <= 32'(b_idx_r)) &&
       (32'(b_idx_r) < (32'(b_wrow_r) + 1) * TABLE_COLUMNS)))
    else $error("write row decode mismatch");

  // only the top height lands on the last row, and then with no fraction
  a_row_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && ctrl_r.is_sample && ctrl_r.row_edge) |-> (ctrl_r.frac_y == '0))
    else $error("last row reached with nonzero fraction");
`endif

endmodule

// ===== src/bits_texel_mem.sv =====
`timescale 1ns / 1ps
// four-bank texel store, one stage: writes one texel or reads a 2x2 footprint
// depends on bits_pkg

module bits_texel_mem import bits_pkg::*; #(
  parameter  int TABLE_COLUMNS = BITS_TABLE_COLUMNS,
  parameter  int TABLE_ROWS    = BITS_TABLE_ROWS,
  localparam int HC_W          = half_w(TABLE_COLUMNS),
  localparam int HR_W          = half_w(TABLE_ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  samp_ctrl_t        up_ctrl,
  input  texel_t            up_texel,
  input  logic [HR_W-1:0]   up_hr_e,
  input  logic [HR_W-1:0]   up_hr_o,
  input  logic [HC_W-1:0]   up_hc_e,
  input  logic [HC_W-1:0]   up_hc_o,
  output logic              dn_valid,
  input  logic              dn_ready,
  output samp_ctrl_t        dn_ctrl,
  output texel_t [BANKS-1:0] dn_rd
);

  localparam int BA_W       = HR_W + HC_W;
  localparam int BANK_DEPTH = 1 << BA_W;

  logic       en;
  logic       v_r;
  samp_ctrl_t ctrl_r;
  logic       rd_en;
  logic       wr_en;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign rd_en    = en && up_valid && up_ctrl.is_sample;
  assign wr_en    = en && up_valid && !up_ctrl.is_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      // writes end here and leave a bubble
      v_r <= up_valid && up_ctrl.is_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= up_ctrl;
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    localparam int B_ROW = (b >> 1) & 1;
    localparam int B_COL = b & 1;

    texel_t            bank_mem_r [BANK_DEPTH];
    texel_t            rd_r;
    logic [BA_W-1:0]   addr;
    logic              hit;

    assign addr = {((B_ROW != 0) ? up_hr_o : up_hr_e), ((B_COL != 0) ? up_hc_o : up_hc_e)};
    assign hit  = ({up_ctrl.row_odd, up_ctrl.col_odd} == BANK_W'(b));

    always_ff @(posedge clk) begin
      if (wr_en && hit) begin
        bank_mem_r[addr] <= up_texel;
      end
      if (rd_en) begin
        rd_r <= bank_mem_r[addr];
      end
    end

    assign dn_rd[b] = rd_r;
  end

  assign dn_valid = v_r;
  assign dn_ctrl  = ctrl_r;

endmodule

// ===== src/bits_blend.sv =====
`timescale 1ns / 1ps
// six-stage bilinear blend of the 2x2 footprint, three channels in parallel
// depends on bits_pkg and bits_out_if

module bits_blend import bits_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  samp_ctrl_t         up_ctrl,
  input  texel_t [BANKS-1:0] up_rd,
  bits_out_if.source         out_item
);

  localparam int STAGES = 6;
  localparam int DIFF_W = TEXEL_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  logic [STAGES-1:0] v_r, v_nxt, en;

  // stage 1: footprint select and column differences
  logic signed [TEXEL_W-1:0] s1_a_top_r [CHANNELS];
  logic signed [TEXEL_W-1:0] s1_a_bot_r [CHANNELS];
  logic signed [DIFF_W-1:0]  s1_d_top_r [CHANNELS];
  logic signed [DIFF_W-1:0]  s1_d_bot_r [CHANNELS];
  logic [FRAC_W-1:0]         s1_fx_r, s1_fy_r;
  // stage 2: column products
  logic signed [TEXEL_W-1:0] s2_a_top_r [CHANNELS];
  logic signed [TEXEL_W-1:0] s2_a_bot_r [CHANNELS];
  logic signed [PROD_W-1:0]  s2_p_top_r [CHANNELS];
  logic signed [PROD_W-1:0]  s2_p_bot_r [CHANNELS];
  logic [FRAC_W-1:0]         s2_fy_r;
  // stage 3: top and bottom rows blended
  logic signed [TEXEL_W-1:0] s3_top_r [CHANNELS];
  logic signed [TEXEL_W-1:0] s3_bot_r [CHANNELS];
  logic [FRAC_W-1:0]         s3_fy_r;
  // stage 4: row difference
  logic signed [TEXEL_W-1:0] s4_top_r [CHANNELS];
  logic signed [DIFF_W-1:0]  s4_d_r [CHANNELS];
  logic [FRAC_W-1:0]         s4_fy_r;
  // stage 5: row product
  logic signed [TEXEL_W-1:0] s5_top_r [CHANNELS];
  logic signed [PROD_W-1:0]  s5_p_r [CHANNELS];
  // stage 6: result, clamped at zero
  logic [OUT_W-1:0]          out_r [CHANNELS];

  logic [BANK_W-1:0]         i00, i10, i01, i11;
  logic signed [TEXEL_W-1:0] t00, t10, t01, t11;
  logic signed [TEXEL_W-1:0] s1_a_top_nxt [CHANNELS];
  logic signed [TEXEL_W-1:0] s1_a_bot_nxt [CHANNELS];
  logic signed [DIFF_W-1:0]  s1_d_top_nxt [CHANNELS];
  logic signed [DIFF_W-1:0]  s1_d_bot_nxt [CHANNELS];
  logic signed [TEXEL_W-1:0] v_sum [CHANNELS];

  function automatic logic signed [TEXEL_W-1:0] chan_of(input texel_t t, input int c);
    logic signed [TEXEL_W-1:0] v;
    case (c)
      0:       v = t.red;
      1:       v = t.green;
      default: v = t.blue;
    endcase
    return v;
  endfunction

  // a + floor((p + half) / 2^16), wrapped to the texel width
  function automatic logic signed [TEXEL_W-1:0] round_add(
    input logic signed [TEXEL_W-1:0] a,
    input logic signed [PROD_W-1:0]  p
  );
    logic signed [PROD_W-1:0] r;
    r = p + PROD_W'(ROUND_HALF);
    return a + TEXEL_W'(r >>> FRAC_W);
  endfunction

  // stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_item.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? up_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign up_ready = en[0];

  // bank of each corner; on the last row the bottom pair repeats the top pair
  always_comb begin
    i00 = {up_ctrl.row_odd, up_ctrl.col_odd};
    i10 = {up_ctrl.row_odd, ~up_ctrl.col_odd};
    i01 = {~up_ctrl.row_odd, up_ctrl.col_odd};
    i11 = {~up_ctrl.row_odd, ~up_ctrl.col_odd};
    for (int c = 0; c < CHANNELS; c++) begin
      t00 = chan_of(up_rd[i00], c);
      t10 = chan_of(up_rd[i10], c);
      t01 = up_ctrl.row_edge ? t00 : chan_of(up_rd[i01], c);
      t11 = up_ctrl.row_edge ? t10 : chan_of(up_rd[i11], c);
      s1_a_top_nxt[c] = t00;
      s1_a_bot_nxt[c] = t01;
      s1_d_top_nxt[c] = $signed({t10[TEXEL_W-1], t10}) - $signed({t00[TEXEL_W-1], t00});
      s1_d_bot_nxt[c] = $signed({t11[TEXEL_W-1], t11}) - $signed({t01[TEXEL_W-1], t01});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_a_top_r <= s1_a_top_nxt;
      s1_a_bot_r <= s1_a_bot_nxt;
      s1_d_top_r <= s1_d_top_nxt;
      s1_d_bot_r <= s1_d_bot_nxt;
      s1_fx_r    <= up_ctrl.frac_x;
      s1_fy_r    <= up_ctrl.frac_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s2_a_top_r[c] <= s1_a_top_r[c];
        s2_a_bot_r[c] <= s1_a_bot_r[c];
        s2_p_top_r[c] <= PROD_W'(s1_d_top_r[c]) * PROD_W'($signed({1'b0, s1_fx_r}));
        s2_p_bot_r[c] <= PROD_W'(s1_d_bot_r[c]) * PROD_W'($signed({1'b0, s1_fx_r}));
      end
      s2_fy_r <= s1_fy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s3_top_r[c] <= round_add(s2_a_top_r[c], s2_p_top_r[c]);
        s3_bot_r[c] <= round_add(s2_a_bot_r[c], s2_p_bot_r[c]);
      end
      s3_fy_r <= s2_fy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s4_top_r[c] <= s3_top_r[c];
        s4_d_r[c]   <= $signed({s3_bot_r[c][TEXEL_W-1], s3_bot_r[c]}) -
                       $signed({s3_top_r[c][TEXEL_W-1], s3_top_r[c]});
      end
      s4_fy_r <= s3_fy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s5_top_r[c] <= s4_top_r[c];
        s5_p_r[c]   <= PROD_W'(s4_d_r[c]) * PROD_W'($signed({1'b0, s4_fy_r}));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      v_sum[c] = round_add(s5_top_r[c], s5_p_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_r[c] <= v_sum[c][TEXEL_W-1] ? '0 : v_sum[c][OUT_W-1:0];
      end
    end
  end

  assign out_item.valid = v_r[STAGES-1];
  assign out_item.red   = out_r[0];
  assign out_item.green = out_r[1];
  assign out_item.blue  = out_r[2];

endmodule

// ===== src/bilinear_irradiance_table_sampler.sv =====
`timescale 1ns / 1ps
// top level of the bilinear irradiance table sampler
// depends on bits_pkg, bits_if, bits_coord, bits_texel_mem and bits_blend

// usage
//   in_item carries one item per valid/ready handshake: action 0 writes one
//   RGB texel at texel_index (row * columns + column), action 1 samples the
//   table at source_cosine (columns) and height_km (rows)
//   out_item returns red, green, blue for every sample item, in order;
//   write items and writes past the table end return nothing
//   an accepted sample reaches out_item.valid through 10 register stages:
//   3 coordinate stages (products, divide-by-15 reciprocal, bank addresses),
//   1 texel read stage and 6 blend stages (two multiply/round passes)
//   throughput is one item per cycle unless out_item stalls; the four corner
//   texels come from four banks split on row and column parity, one read each
//   reset clears the pipeline valid bits only; table contents are undefined
//   until written, and sampling an unwritten texel gives undefined data
//   when out_item.ready is low the full stages hold their items and empty
//   stages keep filling, so in_item.ready drops only once the pipe is full
//   a write reaches the table before any later sample reads it

module bilinear_irradiance_table_sampler import bits_pkg::*; #(
  parameter int TABLE_COLUMNS = BITS_TABLE_COLUMNS,
  parameter int TABLE_ROWS    = BITS_TABLE_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  bits_in_if.sink     in_item,
  bits_out_if.source  out_item
);

  localparam int HC_W = half_w(TABLE_COLUMNS);
  localparam int HR_W = half_w(TABLE_ROWS);

  // coordinate stages to texel store
  logic               co_valid, co_ready;
  samp_ctrl_t         co_ctrl;
  texel_t             co_texel;
  logic [HR_W-1:0]    co_hr_e, co_hr_o;
  logic [HC_W-1:0]    co_hc_e, co_hc_o;

  // texel store to blend stages
  logic               rd_valid, rd_ready;
  samp_ctrl_t         rd_ctrl;
  texel_t [BANKS-1:0] rd_texels;

  bits_coord #(
    .TABLE_COLUMNS(TABLE_COLUMNS),
    .TABLE_ROWS   (TABLE_ROWS)
  ) u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .dn_valid(co_valid),
    .dn_ready(co_ready),
    .dn_ctrl (co_ctrl),
    .dn_texel(co_texel),
    .dn_hr_e (co_hr_e),
    .dn_hr_o (co_hr_o),
    .dn_hc_e (co_hc_e),
    .dn_hc_o (co_hc_o)
  );

  // banked store; a write item finishes here
  bits_texel_mem #(
    .TABLE_COLUMNS(TABLE_COLUMNS),
    .TABLE_ROWS   (TABLE_ROWS)
  ) u_texel_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(co_valid),
    .up_ready(co_ready),
    .up_ctrl (co_ctrl),
    .up_texel(co_texel),
    .up_hr_e (co_hr_e),
    .up_hr_o (co_hr_o),
    .up_hc_e (co_hc_e),
    .up_hc_o (co_hc_o),
    .dn_valid(rd_valid),
    .dn_ready(rd_ready),
    .dn_ctrl (rd_ctrl),
    .dn_rd   (rd_texels)
  );

  // column blend, row blend, clamp; its last stage is the output register
  bits_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(rd_valid),
    .up_ready(rd_ready),
    .up_ctrl (rd_ctrl),
    .up_rd   (rd_texels),
    .out_item(out_item)
  );

endmodule

// ===== test/bilinear_irradiance_table_sampler_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for bilinear_irradiance_table_sampler: random texel loads and
// samples with idle gaps and back-pressure, every result checked against a local predictor
// depends on bits_pkg, bits_if and the sampler rtl

module bilinear_irradiance_table_sampler_tb import bits_pkg::*; ();

  localparam int COLS        = BITS_TABLE_COLUMNS;
  localparam int ROWS        = BITS_TABLE_ROWS;
  localparam int TEXEL_COUNT = COLS * ROWS;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_TAIL  = 20;
  localparam int ITEM_GOAL   = 950;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    action_t                    act;
    logic [INDEX_W-1:0]         idx;
    logic signed [TEXEL_W-1:0]  r;
    logic signed [TEXEL_W-1:0]  g;
    logic signed [TEXEL_W-1:0]  b;
    logic signed [COS_W-1:0]    cosv;
    logic signed [HEIGHT_W-1:0] ht;
  } table_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_t;

  // four corner texels (00, 10, 01, 11) and the two blend fractions
  typedef struct {
    int                corner [4];
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } footprint_t;

  // local copy of the texel table plus the queue of expected rgb results
  class irradiance_scoreboard;
    texel_t tab [TEXEL_COUNT];
    bit     written [TEXEL_COUNT];
    rgb_t   expected_rgb [$];
    int     errors;

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    function footprint_t locate(logic signed [COS_W-1:0] c, logic signed [HEIGHT_W-1:0] h);
      footprint_t fp;
      longint     xq, hh, yq;
      int         ix, iy, ix1, iy1;
      xq = (longint'(c) + 32768) * (COLS - 1);
      hh = longint'(h);
      if (hh < 1) hh = 1;
      if (hh > HEIGHT_TOP) hh = HEIGHT_TOP;
      yq = (hh * (ROWS - 1) * 65536) / HEIGHT_TOP;
      ix = int'(xq >> 16);
      iy = int'(yq >> 16);
      if (ix > COLS - 1) ix = COLS - 1;
      if (iy > ROWS - 1) iy = ROWS - 1;
      ix1 = (ix + 1 < COLS) ? ix + 1 : COLS - 1;
      iy1 = (iy + 1 < ROWS) ? iy + 1 : ROWS - 1;
      fp.corner[0] = iy * COLS + ix;
      fp.corner[1] = iy * COLS + ix1;
      fp.corner[2] = iy1 * COLS + ix;
      fp.corner[3] = iy1 * COLS + ix1;
      fp.fx = xq[FRAC_W-1:0];
      fp.fy = yq[FRAC_W-1:0];
      return fp;
    endfunction

    // a + floor(((b - a) * f + half) / 2^16)
    function longint mix(longint a, longint b, logic [FRAC_W-1:0] f);
      longint p;
      p = (b - a) * longint'({48'd0, f}) + ROUND_HALF;
      return a + (p >>> FRAC_W);
    endfunction

    // columns first, then rows, negatives clamped to zero
    function logic [OUT_W-1:0] shade(longint a00, longint a10, longint a01, longint a11,
                                     logic [FRAC_W-1:0] fx, logic [FRAC_W-1:0] fy);
      longint v;
      v = mix(mix(a00, a10, fx), mix(a01, a11, fx), fy);
      if (v < 0) v = 0;
      return v[OUT_W-1:0];
    endfunction

    function void note_item(table_req_t q);
      footprint_t fp;
      texel_t     t [4];
      rgb_t       e;
      if (q.act == ACT_WRITE) begin
        if (q.idx < TEXEL_COUNT) begin
          tab[q.idx]     = '{red: q.r, green: q.g, blue: q.b};
          written[q.idx] = 1'b1;
        end
      end else begin
        fp = locate(q.cosv, q.ht);
        foreach (t[k]) t[k] = tab[INDEX_W'(fp.corner[k])];
        e.red   = shade(longint'(signed'(t[0].red)), longint'(signed'(t[1].red)),
                        longint'(signed'(t[2].red)), longint'(signed'(t[3].red)), fp.fx, fp.fy);
        e.green = shade(longint'(signed'(t[0].green)), longint'(signed'(t[1].green)),
                        longint'(signed'(t[2].green)), longint'(signed'(t[3].green)),
                        fp.fx, fp.fy);
        e.blue  = shade(longint'(signed'(t[0].blue)), longint'(signed'(t[1].blue)),
                        longint'(signed'(t[2].blue)), longint'(signed'(t[3].blue)),
                        fp.fx, fp.fy);
        expected_rgb.push_back(e);
      end
    endfunction

    task check_result(logic [OUT_W-1:0] r, logic [OUT_W-1:0] g, logic [OUT_W-1:0] b);
      rgb_t e;
      if (expected_rgb.size() == 0) begin
        report($sformatf("result %h %h %h with no sample outstanding", r, g, b));
        return;
      end
      e = expected_rgb.pop_front();
      if (r !== e.red)   report($sformatf("red got %h want %h", r, e.red));
      if (g !== e.green) report($sformatf("green got %h want %h", g, e.green));
      if (b !== e.blue)  report($sformatf("blue got %h want %h", b, e.blue));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bits_in_if  in_if ();
  bits_out_if out_if ();

  bilinear_irradiance_table_sampler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  irradiance_scoreboard sb = new();
  int items_sent;
  int idle_cycles;
  bit calm;      // no gaps and no stalls on either side
  bit hold_req;  // ask the receiver for one long hold-off

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------- stimulus helpers

  function automatic table_req_t scrambled(action_t a);
    table_req_t q;
    q.act  = a;
    q.idx  = INDEX_W'($urandom());
    q.r    = $urandom();
    q.g    = $urandom();
    q.b    = $urandom();
    q.cosv = COS_W'($urandom());
    q.ht   = HEIGHT_W'($urandom());
    return q;
  endfunction

  function automatic logic signed [TEXEL_W-1:0] pick_texel();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 1 << 20);
      1:       return -$signed($urandom_range(0, 1 << 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [COS_W-1:0] pick_cos();
    case ($urandom_range(0, 9))
      0:       return COS_W'(-32768);
      1:       return COS_W'(32767);
      default: return COS_W'($urandom());
    endcase
  endfunction

  // mostly inside the clamp range, with the edges and far outside mixed in
  function automatic logic signed [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return HEIGHT_W'($urandom());
      1:       return HEIGHT_W'($signed($urandom_range(0, 2)) - 1);
      2:       return HEIGHT_W'(HEIGHT_TOP - 1 + $urandom_range(0, 2));
      3:       return HEIGHT_W'(-$signed($urandom_range(1, 1 << 23)));
      default: return HEIGHT_W'($urandom_range(0, HEIGHT_TOP));
    endcase
  endfunction

  // offer one item and hold it until the block takes it
  task automatic offer(input table_req_t q);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.action        <= q.act;
    in_if.texel_index   <= q.idx;
    in_if.texel_red     <= q.r;
    in_if.texel_green   <= q.g;
    in_if.texel_blue    <= q.b;
    in_if.source_cosine <= q.cosv;
    in_if.height_km     <= q.ht;
    in_if.valid         <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_item(q);
    items_sent++;
  endtask

  task automatic write_texel(input int idx, input logic signed [TEXEL_W-1:0] r,
                             input logic signed [TEXEL_W-1:0] g,
                             input logic signed [TEXEL_W-1:0] b);
    table_req_t q;
    q     = scrambled(ACT_WRITE);
    q.idx = INDEX_W'(idx);
    q.r   = r;
    q.g   = g;
    q.b   = b;
    offer(q);
  endtask

  // load any corner that is still unwritten, then sample
  task automatic sample_at(input logic signed [COS_W-1:0] c,
                           input logic signed [HEIGHT_W-1:0] h);
    footprint_t fp;
    table_req_t q;
    fp = sb.locate(c, h);
    foreach (fp.corner[k])
      if (!sb.written[INDEX_W'(fp.corner[k])])
        write_texel(fp.corner[k], pick_texel(), pick_texel(), pick_texel());
    q      = scrambled(ACT_SAMPLE);
    q.cosv = c;
    q.ht   = h;
    offer(q);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 3) == 0)
      write_texel($urandom_range(0, TEXEL_COUNT - 1), pick_texel(), pick_texel(), pick_texel());
    else
      sample_at(pick_cos(), pick_height());
  endtask

  // drop valid and wait for the pipe to hand back everything
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_rgb.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      sb.check_result(out_if.red, out_if.green, out_if.blue);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bilinear_irradiance_table_sampler_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int base;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.action        <= ACT_WRITE;
    in_if.texel_index   <= '0;
    in_if.texel_red     <= '0;
    in_if.texel_green   <= '0;
    in_if.texel_blue    <= '0;
    in_if.source_cosine <= '0;
    in_if.height_km     <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // opposite extremes in the first footprint so blends span the full range
    write_texel(0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000);
    write_texel(1, 32'sh80000000, 32'sh7fffffff, -1);
    write_texel(COLS, 0, -1, 32'sh7fffffff);
    write_texel(COLS + 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    // min cosine, min height: height raised to one unit
    sample_at(COS_W'(-32768), HEIGHT_W'(-8388608));
    // column fraction close to one between max and min texels
    sample_at(COS_W'(-32768 + 1040), HEIGHT_W'(0));
    sample_at(COS_W'(-32768 + 1040), HEIGHT_W'(1));
    // last row and column, all-ones index
    write_texel(TEXEL_COUNT - 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    write_texel(TEXEL_COUNT - 2, 32'sh80000000, 32'sh00000000, 32'sh7fffffff);
    // max cosine, max height: neighbour row clamped to the edge
    sample_at(COS_W'(32767), HEIGHT_W'(8388607));
    sample_at(COS_W'(32767), HEIGHT_W'(HEIGHT_TOP));
    sample_at(COS_W'(32767), HEIGHT_W'(HEIGHT_TOP + 1));
    // half fractions in the middle of the table
    sample_at(COS_W'(0), HEIGHT_W'(HEIGHT_TOP / 2));
    sample_at(COS_W'(-32768), HEIGHT_W'(HEIGHT_TOP));
    sample_at(COS_W'(-1), HEIGHT_W'(4096));

    // random phases: gappy, gap-free, one long result hold-off with a full pipe
    for (int ph = 0; ph < 8 && items_sent < ITEM_GOAL; ph++) begin
      calm = (ph % 3 == 1);
      if (ph == 4) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      base = items_sent;
      while (items_sent < base + 120 && items_sent < ITEM_GOAL) random_item();
      // sender pause until every sample has come back
      if (ph == 4 || ph == 6) drain();
    end
    calm = 1'b0;

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.errors == 0)
      $display("bilinear_irradiance_table_sampler_tb: done, clean");
    else
      $display("bilinear_irradiance_table_sampler_tb: done, errors");
    $finish;
  end

endmodule
